[sv/byte_ring_buffer_burst_assert.svh]
// Assertion macros shared by the FIFO modules.
// Both expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef BYTE_RING_BUFFER_BURST_ASSERT_SVH
`define BYTE_RING_BUFFER_BURST_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BRB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brb assertion failed");
// next-cycle implication
`define BRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brb assertion failed");
`else
`define BRB_ASSERT_NOW(lbl, ante, cons)
`define BRB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/brb_pkg.sv]
package brb_pkg;

    // default build parameters
    localparam int DEPTH_DEF     = 256;
    localparam int MAX_BURST_DEF = 8;

    // item opcodes
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;
    localparam t_opcode OP_NOP   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch an accepted item
        logic decide;    // check space / clamp read / clear
        logic step_wr;   // write one byte
        logic step_rd;   // issue or capture one byte read
        logic load_out;  // load the result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        t_opcode op;
        logic    wr_fits;
        logic    wr_last;
        logic    rd_idle;
    } t_stat;

endpackage

[sv/brb_dp.sv]
`include "byte_ring_buffer_burst_assert.svh"

module brb_dp #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  brb_pkg::t_cmd  i_cmd,
    output brb_pkg::t_stat o_stat,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data,
    input  logic [1:0]    i_opcode,
    input  logic [3:0]    i_byte_count,
    input  logic [63:0]   i_write_bytes,
    output logic [3:0]    o_done_count,
    output logic [63:0]   o_read_bytes,
    output logic          o_write_refused,
    output logic [7:0]    o_stored_count,
    output logic [7:0]    o_free_count,
    output logic [31:0]   o_overflow_total
);
    import brb_pkg::*;

    // pointers and memory never pass 256 slots even when DEPTH is larger
    localparam int LIM = (DEPTH < 256) ? DEPTH : 256;
    localparam int AW  = $clog2(LIM);
    localparam int SW  = $clog2(LIM + 1);

    logic [7:0]    mem [LIM];
    logic [7:0]    r_mem_q;

    logic [AW-1:0] r_wp, r_rp;
    logic [SW-1:0] r_size;
    logic [31:0]   r_ovf;
    logic          r_rd_pend;
    t_opcode       r_op;
    logic [3:0]    r_cnt;
    logic [3:0]    r_done;
    logic [2:0]    r_idx;
    logic [63:0]   r_wdata;
    logic [63:0]   r_rdata;
    logic          r_refused;

    logic [SW-1:0] stored, space, wp_inc, rp_inc, cfg_size;
    logic [AW-1:0] wp_adv, rp_adv;
    logic [3:0]    cnt_in, rd_cnt;
    logic          fits;

    // occupancy and free space
    always_comb begin
        if (r_wp >= r_rp) begin
            stored = SW'(r_wp) - SW'(r_rp);
        end else begin
            stored = r_size + SW'(r_wp) - SW'(r_rp);
        end
        space = r_size - SW'(1) - stored;
        fits  = (9'(r_cnt) <= 9'(space));
        rd_cnt = (9'(r_cnt) > 9'(stored)) ? 4'(stored) : r_cnt;
    end

    // pointer advance with wrap at the configured size
    always_comb begin
        wp_inc = SW'(r_wp) + SW'(1);
        rp_inc = SW'(r_rp) + SW'(1);
        wp_adv = (wp_inc >= r_size) ? '0 : AW'(wp_inc);
        rp_adv = (rp_inc >= r_size) ? '0 : AW'(rp_inc);
    end

    // size clamp and burst clamp
    always_comb begin
        if (i_cfg_data < 9'd2) begin
            cfg_size = SW'(2);
        end else if (i_cfg_data > 9'(LIM)) begin
            cfg_size = SW'(LIM);
        end else begin
            cfg_size = SW'(i_cfg_data);
        end
        cnt_in = (i_byte_count > 4'(MAX_BURST)) ? 4'(MAX_BURST) : i_byte_count;
    end

    // status to controller
    always_comb begin
        o_stat.op      = r_op;
        o_stat.wr_fits = fits;
        o_stat.wr_last = (r_cnt <= 4'd1);
        o_stat.rd_idle = (r_cnt == 4'd0) && !r_rd_pend;
    end

    // pointers, size, overflow counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_size    <= SW'(LIM);
            r_ovf     <= '0;
            r_rd_pend <= 1'b0;
        end else if (i_cfg_we) begin
            r_size <= cfg_size;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            if (i_cmd.decide) begin
                if (r_op == OP_WRITE && !fits) begin
                    r_ovf <= r_ovf + 32'd1;
                end else if (r_op == OP_CLEAR) begin
                    r_wp  <= '0;
                    r_rp  <= '0;
                    r_ovf <= '0;
                end
            end
            if (i_cmd.step_wr && r_cnt != 4'd0) begin
                r_wp <= wp_adv;
            end
            if (i_cmd.step_rd) begin
                r_rd_pend <= (r_cnt != 4'd0);
                if (r_cnt != 4'd0) begin
                    r_rp <= rp_adv;
                end
            end
        end
    end

    // item payload, byte loop and memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_cnt     <= cnt_in;
            r_wdata   <= i_write_bytes;
            r_rdata   <= '0;
            r_refused <= 1'b0;
            r_done    <= '0;
            r_idx     <= '0;
        end
        if (i_cmd.decide) begin
            if (r_op == OP_WRITE) begin
                if (fits) begin
                    r_done <= r_cnt;
                end else begin
                    r_refused <= 1'b1;
                end
            end else if (r_op == OP_READ) begin
                r_cnt  <= rd_cnt;
                r_done <= rd_cnt;
            end
        end
        if (i_cmd.step_wr && r_cnt != 4'd0) begin
            mem[r_wp] <= r_wdata[7:0];
            r_wdata   <= r_wdata >> 8;
            r_cnt     <= r_cnt - 4'd1;
        end
        if (i_cmd.step_rd) begin
            if (r_cnt != 4'd0) begin
                r_mem_q <= mem[r_rp];
                r_cnt   <= r_cnt - 4'd1;
            end
            if (r_rd_pend) begin
                r_rdata[{r_idx, 3'b000} +: 8] <= r_mem_q;
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_done_count     <= r_done;
            o_read_bytes     <= r_rdata;
            o_write_refused  <= r_refused;
            o_stored_count   <= 8'(stored);
            o_free_count     <= 8'(space);
            o_overflow_total <= r_ovf;
        end
    end

    `BRB_ASSERT_NOW(a_ptr_in_range, 1'b1, (SW'(r_wp) < r_size) && (SW'(r_rp) < r_size))
    `BRB_ASSERT_NEXT(a_refuse_counts, i_cmd.decide && !i_cfg_we && r_op == OP_WRITE && !fits,
        r_ovf == $past(r_ovf) + 32'd1)
    `BRB_ASSERT_NOW(a_done_bound, i_cmd.load_out, r_done <= 4'(MAX_BURST))

endmodule

[sv/brb_ctrl.sv]
`include "byte_ring_buffer_burst_assert.svh"

module brb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  brb_pkg::t_stat i_stat,
    output brb_pkg::t_cmd  o_cmd
);
    import brb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_READ,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // commands for the current state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.step_wr  = (r_state == S_WRITE);
        o_cmd.step_rd  = (r_state == S_READ);
        o_cmd.load_out = (r_state == S_FINISH) && slot_free;
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes the slot in the same cycle the old one leaves
            if (r_out_valid && !i_out_stall && !o_cmd.load_out) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (i_stat.op == OP_WRITE && i_stat.wr_fits) begin
                        r_state <= S_WRITE;
                    end else if (i_stat.op == OP_READ) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_WRITE: begin
                    if (i_stat.wr_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_READ: begin
                    if (i_stat.rd_idle) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BRB_ASSERT_NEXT(a_accept_to_decide, i_in_valid && !o_in_stall, r_state == S_DECIDE)
    `BRB_ASSERT_NEXT(a_load_sets_valid, o_cmd.load_out, r_out_valid)
    `BRB_ASSERT_NEXT(a_finish_waits, r_state == S_FINISH && r_out_valid && i_out_stall,
        r_state == S_FINISH)

endmodule

[sv/byte_ring_buffer_burst.sv]
// Circular byte FIFO, one byte per cycle through a single byte-wide memory.
// An item goes decide, then a byte loop over the memory port (writes that fit, and
// reads, which also capture the last byte read), then finish; refused writes, clears
// and no-ops skip the loop. Result valid is registered in finish, which waits while
// an earlier stalled result holds the slot. Synchronous active-low reset: pointers
// and overflow count zero, size at full depth; memory contents are not cleared.
module byte_ring_buffer_burst #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_write_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_done_count,
    output logic [63:0] o_read_bytes,
    output logic        o_write_refused,
    output logic [7:0]  o_stored_count,
    output logic [7:0]  o_free_count,
    output logic [31:0] o_overflow_total
);
    import brb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    brb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // pointers, memory and result register
    brb_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_byte_count     (i_byte_count),
        .i_write_bytes    (i_write_bytes),
        .o_done_count     (o_done_count),
        .o_read_bytes     (o_read_bytes),
        .o_write_refused  (o_write_refused),
        .o_stored_count   (o_stored_count),
        .o_free_count     (o_free_count),
        .o_overflow_total (o_overflow_total)
    );

endmodule
